### sv/skps_pkg.sv
// Shared types and constants for the sorted key pair set.
// Standalone package; imported by every module of the block but skps_ram.
package skps_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FIELD_W     = 64;
  localparam int unsigned KEY_W       = 4 * FIELD_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

### sv/skps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/skps_cmp.sv
// Unsigned 256-bit key comparator: search key against one stored entry.
// Uses skps_pkg.
module skps_cmp (
  input  skps_pkg::key_t key_i,
  input  skps_pkg::key_t entry_i,
  output skps_pkg::cmp_t cmp_o
);
  import skps_pkg::*;

  assign cmp_o.eq = (key_i == entry_i);
  assign cmp_o.lt = (key_i < entry_i);

endmodule

### sv/sorted_key_pair_set.sv
// Top level of the sorted key pair set: control sequencer around the key RAM.
// Uses skps_pkg, skps_ram and skps_cmp.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------
//  command   | start / busy      | opcode_i, class_id_*_i, iface_id_*_i
//  result    | done_o (strobe)   | status_o, entry_count_o
//
// One command is worked at a time. A word is taken when start is high and
// busy is low. Clear answers on the next cycle. Add, remove and check run a
// binary search in which each probe reads the RAM (S_PROBE) and compares the
// registered read data (S_CMP); then add and remove move the entries above
// the insertion point or the hit, one per cycle, through the RAM's separate
// read and write ports, and add then writes the new key in S_INS. The result
// shows for one cycle on done_o and cannot be stalled. Reset clears the count
// and the control registers but not the RAM, which is never cleared since
// only entries below the count are read.
module sorted_key_pair_set (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode_i,
  input  logic [63:0]             class_id_high_i,
  input  logic [63:0]             class_id_low_i,
  input  logic [63:0]             iface_id_high_i,
  input  logic [63:0]             iface_id_low_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [skps_pkg::CNT_W-1:0] entry_count_o
);
  import skps_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic              pend_q, pend_d;

  // search and move datapath registers
  logic [1:0]        op_q, op_d;
  key_t              key_q, key_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0] mid_q, mid_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] psrc_q, psrc_d;
  logic [CNT_W-1:0]  rem_q, rem_d;

  logic [CNT_W-1:0]  mid_w;
  logic              accept;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  key_t              ram_wdata, ram_rdata;
  cmp_t              cmp;

  skps_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  skps_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (ram_rdata),
    .cmp_o   (cmp)
  );

  assign accept = start && (state_q == S_IDLE);
  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    pend_d    = 1'b0;
    op_d      = op_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    pos_d     = pos_q;
    mid_d     = mid_q;
    src_d     = src_q;
    psrc_d    = psrc_q;
    rem_d     = rem_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q[ADDR_W-1:0];
    ram_wdata = key_q;
    ram_raddr = src_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = opcode_i;
          key_d = {class_id_high_i, class_id_low_i, iface_id_high_i, iface_id_low_i};
          lo_d  = '0;
          hi_d  = count_q;
          if (opcode_i == OP_CLEAR) begin
            // clear answers without a search
            count_d  = '0;
            status_d = ST_OK;
            done_d   = 1'b1;
          end else begin
            state_d = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (lo_q < hi_q) begin
          // issue the probe read; compare next cycle
          ram_raddr = mid_w[ADDR_W-1:0];
          mid_d     = mid_w[ADDR_W-1:0];
          state_d   = S_CMP;
        end else begin
          // key absent; lo is the insertion point
          pos_d = lo_q;
          if (op_q == OP_ADD && count_q < DEPTH_CNT) begin
            rem_d   = count_q - lo_q;
            src_d   = ADDR_W'(count_q - CNT_W'(1));
            state_d = S_SHIFT;
          end else begin
            status_d = (op_q == OP_ADD) ? ST_FULL : ST_MISS;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end

      S_CMP: begin
        if (cmp.eq) begin
          if (op_q == OP_REMOVE) begin
            // close the gap: move entries above the hit down by one
            rem_d   = count_q - CNT_W'(mid_q) - CNT_W'(1);
            src_d   = mid_q + ADDR_W'(1);
            state_d = S_SHIFT;
          end else begin
            status_d = (op_q == OP_ADD) ? ST_MISS : ST_OK;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          if (cmp.lt) begin
            hi_d = CNT_W'(mid_q);
          end else begin
            lo_d = CNT_W'(mid_q) + CNT_W'(1);
          end
          state_d = S_PROBE;
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle, one slot up or down
        ram_we    = pend_q;
        ram_wdata = ram_rdata;
        ram_waddr = (op_q == OP_ADD) ? psrc_q + ADDR_W'(1) : psrc_q - ADDR_W'(1);
        if (rem_q != '0) begin
          ram_raddr = src_q;
          pend_d    = 1'b1;
          psrc_d    = src_q;
          src_d     = (op_q == OP_ADD) ? src_q - ADDR_W'(1) : src_q + ADDR_W'(1);
          rem_d     = rem_q - CNT_W'(1);
        end else if (!pend_q) begin
          if (op_q == OP_ADD) begin
            state_d = S_INS;
          end else begin
            count_d  = count_q - CNT_W'(1);
            status_d = ST_OK;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[ADDR_W-1:0];
        ram_wdata = key_q;
        count_d   = count_q + CNT_W'(1);
        status_d  = ST_OK;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    pos_q  <= pos_d;
    mid_q  <= mid_d;
    src_q  <= src_d;
    psrc_q <= psrc_d;
    rem_q  <= rem_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

### sv/skps_chk.sv
// Port-level checker for the sorted key pair set, bound to the top level.
// Uses skps_pkg.
module skps_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   opcode_i,
  input logic                         done_o,
  input logic [1:0]                   status_o,
  input logic [skps_pkg::CNT_W-1:0]   entry_count_o
);
  import skps_pkg::*;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_clear_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_CLEAR) |=>
      (done_o && status_o == ST_OK && entry_count_o == '0))
    else $error("clear did not answer empty on the next cycle");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> entry_count_o == DEPTH_CNT)
    else $error("full status with table not full");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_MISS || status_o == ST_FULL))
    else $error("unknown status code");

endmodule

bind sorted_key_pair_set skps_chk u_skps_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .opcode_i      (opcode_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);

### tb/tb_sorted_key_pair_set.sv
// Self-checking bench for sorted_key_pair_set: directed and random add, remove,
// check and clear words against an in-bench ordered-set predictor.
// Depends on skps_pkg and the sorted_key_pair_set RTL only.
`timescale 1ns / 1ps

module tb_sorted_key_pair_set;
  import skps_pkg::*;

  localparam int unsigned RANDOM_TARGET = 1050;
  localparam int unsigned SETTLE_CYCLES = 300;

  // One command word as the bench holds it before driving.
  typedef struct {
    logic [1:0] opcode;
    key_t       key;      // {class_high, class_low, iface_high, iface_low}
    bit         drain;    // hold this word until every pending result is back
    int         gap_pct;  // chance per cycle that start is held low
  } set_cmd_t;

  typedef struct {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } set_reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       opcode_i = OP_CHECK;
  logic [63:0]      class_id_high_i = '0;
  logic [63:0]      class_id_low_i = '0;
  logic [63:0]      iface_id_high_i = '0;
  logic [63:0]      iface_id_low_i = '0;
  logic             done_o;
  logic [1:0]       status_o;
  logic [CNT_W-1:0] entry_count_o;

  sorted_key_pair_set dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .class_id_high_i(class_id_high_i),
    .class_id_low_i (class_id_low_i),
    .iface_id_high_i(iface_id_high_i),
    .iface_id_low_i (iface_id_low_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  // Clock and the single reset pulse.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: the stored keys as an ascending queue. A 256-bit unsigned
  // compare of {class_high, class_low, iface_high, iface_low} gives exactly the
  // block's byte order, so plain relational operators do the ordering.
  // ---------------------------------------------------------------------------
  key_t       stored_keys_q[$];
  set_reply_t pending_replies_q[$];

  int unsigned n_add, n_remove, n_check, n_clear;
  int unsigned n_full_hits, n_dup_hits, n_remove_hits, peak_fill;
  int unsigned fail_cnt;

  // Binary search; slot gets the match or the insertion point.
  function automatic bit locate_key(key_t k, output int unsigned slot);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = stored_keys_q.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (k == stored_keys_q[mid]) begin
        slot = mid;
        return 1'b1;
      end
      if (k < stored_keys_q[mid]) hi = mid;
      else lo = mid + 1;
    end
    slot = lo;
    return 1'b0;
  endfunction

  // Apply one word to the predicted set and return the reply it must give.
  function automatic set_reply_t apply_set_op(set_cmd_t c);
    set_reply_t  r;
    int unsigned slot;
    bit          hit;
    r.status = ST_OK;
    hit = locate_key(c.key, slot);
    case (c.opcode)
      OP_ADD: begin
        n_add++;
        // A duplicate wins over a full table.
        if (hit) begin
          r.status = ST_MISS;
          n_dup_hits++;
        end else if (stored_keys_q.size() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          n_full_hits++;
        end else begin
          stored_keys_q.insert(slot, c.key);
        end
      end
      OP_REMOVE: begin
        n_remove++;
        if (hit) begin
          stored_keys_q.delete(slot);
          n_remove_hits++;
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_CHECK: begin
        n_check++;
        r.status = hit ? ST_OK : ST_MISS;
      end
      default: begin
        // Clear ignores the key fields.
        n_clear++;
        stored_keys_q.delete();
      end
    endcase
    if (stored_keys_q.size() > peak_fill) peak_fill = stored_keys_q.size();
    r.count = CNT_W'(stored_keys_q.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present one word at a time. A word counts as taken once the
  // monitor has seen start high with busy low; until then hold the fields and
  // only let start drop for random gaps. Drive on the falling edge.
  // ---------------------------------------------------------------------------
  set_cmd_t    cmd_q[$];
  set_cmd_t    cur_cmd;
  int unsigned issued_cnt;
  int unsigned taken_cnt;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (issued_cnt == taken_cnt && cmd_q.size() != 0 &&
          !(cmd_q[0].drain && pending_replies_q.size() != 0)) begin
        cur_cmd = cmd_q.pop_front();
        issued_cnt++;
        opcode_i        <= cur_cmd.opcode;
        class_id_high_i <= cur_cmd.key[255:192];
        class_id_low_i  <= cur_cmd.key[191:128];
        iface_id_high_i <= cur_cmd.key[127:64];
        iface_id_low_i  <= cur_cmd.key[63:0];
      end
      // One assignment to start per step: high only while a word is held and
      // this cycle is not chosen as a gap.
      start <= (issued_cnt != taken_cnt) && ($urandom_range(99) >= cur_cmd.gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge check a strobed reply against the oldest
  // expectation first, then record a word taken on this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_replies_q.size() == 0) begin
          $error("reply with nothing pending: status %0d entry_count %0d",
                 status_o, entry_count_o);
          fail_cnt++;
        end else begin
          set_reply_t want;
          want = pending_replies_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_cnt++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        pending_replies_q.push_back(apply_set_op(cur_cmd));
        taken_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  key_t added_pool_q[$];  // keys sent with add, to aim removes and checks at
  int   cur_gap;

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Field drawn from a narrow alphabet so that keys often tie in the upper
  // words and the compare must reach the lower ones.
  function automatic logic [63:0] pick_field();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(3));
      default: return rand_word();
    endcase
  endfunction

  function automatic key_t mixed_key();
    return {pick_field(), pick_field(), pick_field(), pick_field()};
  endfunction

  function automatic key_t fresh_key();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  function automatic key_t pool_key();
    if (added_pool_q.size() == 0) return mixed_key();
    return added_pool_q[$urandom_range(added_pool_q.size() - 1)];
  endfunction

  task automatic push_cmd(logic [1:0] op, key_t k, bit drain = 1'b0);
    set_cmd_t c;
    c.opcode  = op;
    c.key     = k;
    c.drain   = drain;
    c.gap_pct = cur_gap;
    cmd_q.push_back(c);
    if (op == OP_ADD) added_pool_q.push_back(k);
    if (op == OP_CLEAR) added_pool_q.delete();
    if (added_pool_q.size() > 400) void'(added_pool_q.pop_front());
  endtask

  // Clear, then add fresh keys past capacity; probe duplicate-at-full,
  // remove from a full table and refill it.
  task automatic fill_to_capacity();
    key_t first;
    push_cmd(OP_CLEAR, fresh_key());
    first = fresh_key();
    push_cmd(OP_ADD, first);
    for (int i = 1; i < TABLE_DEPTH + 2; i++) push_cmd(OP_ADD, fresh_key());
    push_cmd(OP_ADD, first);
    push_cmd(OP_CHECK, first);
    push_cmd(OP_REMOVE, first);
    push_cmd(OP_ADD, fresh_key());
    push_cmd(OP_ADD, fresh_key());
  endtask

  task automatic well_formed_burst();
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(10, 40);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)      push_cmd(OP_ADD, mixed_key());
      else if (pick < 45) push_cmd(OP_ADD, pool_key());
      else if (pick < 65) push_cmd(OP_REMOVE, pool_key());
      else if (pick < 73) push_cmd(OP_REMOVE, mixed_key());
      else if (pick < 88) push_cmd(OP_CHECK, pool_key());
      else if (pick < 98) push_cmd(OP_CHECK, mixed_key());
      else                push_cmd(OP_CLEAR, fresh_key());
    end
  endtask

  task automatic noise_burst();
    int unsigned len;
    len = $urandom_range(5, 15);
    for (int unsigned i = 0; i < len; i++)
      push_cmd(2'($urandom_range(3)), fresh_key());
  endtask

  initial begin
    int   gap_plan[3];
    int   seq_idx;
    int   total;
    bit   filled;
    key_t ones_key;
    key_t near_top;
    key_t msb_key;
    gap_plan = '{0, 86, 13};
    ones_key = '1;
    near_top = {{192{1'b1}}, 64'hFFFF_FFFF_FFFF_FFFE};
    msb_key  = {64'h8000_0000_0000_0000, 192'd0};

    // Directed: empty-table misses, extreme keys, a duplicate, neighbors that
    // differ only in the last bit, removal at each end and clear with junk.
    cur_gap = 0;
    push_cmd(OP_CHECK, '0);
    push_cmd(OP_REMOVE, ones_key);
    push_cmd(OP_CLEAR, ones_key);
    push_cmd(OP_ADD, ones_key);
    push_cmd(OP_ADD, '0);
    push_cmd(OP_ADD, '0);
    push_cmd(OP_ADD, near_top);
    push_cmd(OP_ADD, msb_key);
    push_cmd(OP_CHECK, ones_key);
    push_cmd(OP_CHECK, key_t'(1));
    push_cmd(OP_REMOVE, near_top);
    push_cmd(OP_REMOVE, near_top);
    push_cmd(OP_CHECK, near_top);
    push_cmd(OP_REMOVE, '0);
    push_cmd(OP_REMOVE, ones_key);
    push_cmd(OP_CHECK, msb_key);
    push_cmd(OP_CLEAR, fresh_key(), 1'b1);
    push_cmd(OP_CHECK, msb_key);
    push_cmd(OP_REMOVE, msb_key);

    // Random: rotate sender gap phases per sequence; most sequences are
    // well-formed, the rest noise, with one full-capacity pass early on.
    seq_idx = 0;
    filled  = 1'b0;
    total   = cmd_q.size();
    while (total < RANDOM_TARGET) begin
      cur_gap = gap_plan[seq_idx % 3];
      if (!filled && total > 250) begin
        fill_to_capacity();
        filled = 1'b1;
      end else if ($urandom_range(99) < 75) begin
        well_formed_burst();
      end else begin
        noise_burst();
      end
      // Drain before each phase change now and then.
      if (seq_idx % 7 == 3) push_cmd(OP_CHECK, pool_key(), 1'b1);
      total = total + 0;
      total = RANDOM_TARGET - RANDOM_TARGET + (cmd_q.size() + issued_cnt);
      seq_idx++;
    end

    // Wait for everything to be taken and answered, then settle.
    @(posedge rst_ni);
    while (cmd_q.size() != 0 || issued_cnt != taken_cnt || pending_replies_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d words: %0d add, %0d remove, %0d check, %0d clear",
             taken_cnt, n_add, n_remove, n_check, n_clear);
    $display("duplicates %0d, full rejects %0d, removes hit %0d, peak fill %0d",
             n_dup_hits, n_full_hits, n_remove_hits, peak_fill);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1100 words plus
  // sender gaps.
  initial begin
    #(12_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
sv/skps_pkg.sv
sv/skps_ram.sv
sv/skps_cmp.sv
sv/sorted_key_pair_set.sv
sv/skps_chk.sv
tb/tb_sorted_key_pair_set.sv
